@@ hw/rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, word types and per-stage records of the quadratic solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    // Coefficient / root format
    localparam int QRS_W   = 32;                  // word width
    localparam int QRS_F   = 16;                  // fraction bits
    localparam int QRS_TW  = 16;                  // tolerance register width

    // Derived internal widths
    localparam int QRS_PW  = 2 * QRS_W;           // magnitude product
    localparam int QRS_DDW = 2 * QRS_W + 3;       // discriminant magnitude
    localparam int QRS_DQW = QRS_DDW - QRS_F;     // discriminant at Q.F
    localparam int QRS_SW  = QRS_W + 2;           // square root bits (one per cell)
    localparam int QRS_NW  = QRS_W + 3;           // numerator magnitude
    localparam int QRS_DNW = QRS_W + 1;           // denominator magnitude (2|a|)
    localparam int QRS_QB  = QRS_W + 1;           // quotient bits (one per cell)
    localparam int QRS_HW  = QRS_NW + QRS_F - QRS_QB; // dividend bits above quotient

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_INF  = 2'd3
    } t_count;

    typedef struct packed {
        logic signed [QRS_W-1:0] coef_a;
        logic signed [QRS_W-1:0] coef_b;
        logic signed [QRS_W-1:0] coef_c;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              solution_count;
        logic signed [QRS_W-1:0] root_first;
        logic signed [QRS_W-1:0] root_second;
        logic                    saturated;
    } t_out_word;

    // Context carried along the square root chain
    typedef struct packed {
        t_count             cnt;
        logic               en1;
        logic               en2;
        logic               quad;     // numerators still need the root
        logic               qneg1;
        logic               qneg2;
        logic               an;
        logic               bn;
        logic [QRS_W-1:0]   bm;
        logic [QRS_NW-1:0]  n1mag;
        logic [QRS_NW-1:0]  n2mag;
        logic [QRS_DNW-1:0] d1mag;
        logic [QRS_DNW-1:0] d2mag;
    } t_ctx;

    // Square root cell state (restoring, two radicand bits per cell)
    typedef struct packed {
        logic [QRS_SW+1:0]   rem;
        logic [QRS_SW-1:0]   root;
        logic [2*QRS_SW-1:0] dsh;
    } t_sq;

    // Divider cell state (restoring, one quotient bit per cell)
    typedef struct packed {
        logic               en;
        logic               qneg;
        logic               ovf;
        logic [QRS_DNW-1:0] rem;
        logic [QRS_DNW-1:0] dmag;
        logic [QRS_QB-1:0]  nlow;
        logic [QRS_QB-1:0]  q;
    } t_dv;

    // Near-zero test of a word magnitude
    function automatic logic near_zero(input logic [QRS_W-1:0] mag,
                                       input logic [QRS_TW-1:0] tol);
        near_zero = (mag == '0) || (mag < {{(QRS_W-QRS_TW){1'b0}}, tol});
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One restoring square root step: brings down two radicand bits, decides one
// root bit, and registers the result with the item's context.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire qrs_pkg::t_ctx i_ctx,
    input  wire qrs_pkg::t_sq  i_sq,
    output qrs_pkg::t_ctx      o_ctx,
    output qrs_pkg::t_sq       o_sq
);
    import qrs_pkg::*;

    logic [QRS_SW+3:0] w_tmp;
    logic [QRS_SW+3:0] w_trial;
    t_sq               n_sq;
    t_ctx              r_ctx;
    t_sq               r_sq;

    // trial subtract of (4*root + 1)
    always_comb begin
        w_tmp   = {i_sq.rem, i_sq.dsh[2*QRS_SW-1 -: 2]};
        w_trial = {2'b00, i_sq.root, 2'b01};
        n_sq.dsh = {i_sq.dsh[2*QRS_SW-3:0], 2'b00};
        if (w_tmp >= w_trial) begin
            n_sq.rem  = (QRS_SW+2)'(w_tmp - w_trial);
            n_sq.root = {i_sq.root[QRS_SW-2:0], 1'b1};
        end else begin
            n_sq.rem  = (QRS_SW+2)'(w_tmp);
            n_sq.root = {i_sq.root[QRS_SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_sq  <= n_sq;
        end
    end

    assign o_ctx = r_ctx;
    assign o_sq  = r_sq;

endmodule

`default_nettype wire

@@ hw/rtl/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step: shifts in one dividend bit, decides one
// quotient bit, registers the partial state.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire qrs_pkg::t_dv i_dv,
    output qrs_pkg::t_dv      o_dv
);
    import qrs_pkg::*;

    logic [QRS_DNW:0] w_tmp;
    logic             w_take;
    t_dv              n_dv;
    t_dv              r_dv;

    always_comb begin
        w_tmp  = {i_dv.rem, i_dv.nlow[QRS_QB-1]};
        w_take = (w_tmp >= {1'b0, i_dv.dmag});
        n_dv      = i_dv;
        n_dv.nlow = {i_dv.nlow[QRS_QB-2:0], 1'b0};
        n_dv.q    = {i_dv.q[QRS_QB-2:0], w_take};
        if (w_take) begin
            n_dv.rem = QRS_DNW'(w_tmp - {1'b0, i_dv.dmag});
        end else begin
            n_dv.rem = QRS_DNW'(w_tmp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

`default_nettype wire

@@ hw/rtl/quadratic_root_solver_core.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                                  | moves
//  --------+------------------------------------------+--------------------
//  in      | i_in_valid  o_in_ready  i_in_word        | one coefficient word
//  out     | o_out_valid i_out_ready o_out_word       | one result word
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_data       | zero_tolerance
//
//  Pipeline steps in order: split, multiply, discriminant, one cell per root
//  bit, numerators, divider setup, one cell per quotient bit, output register.
//  One word per cycle sustained while the output is not stalled.
//  Reset clears the valid chain and loads a tolerance of 1.
//  An output stall freezes the whole chain; a one-word skid at the input
//  still takes a word while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire qrs_pkg::t_in_word     i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output qrs_pkg::t_out_word         o_out_word,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [qrs_pkg::QRS_TW-1:0] i_cfg_data
);
    import qrs_pkg::*;

    localparam int L = 6 + QRS_SW + QRS_QB;
    localparam logic [QRS_QB-1:0] LIM_POS = {{(QRS_QB-QRS_W+1){1'b0}}, {(QRS_W-1){1'b1}}};
    localparam logic [QRS_QB-1:0] LIM_NEG = LIM_POS + QRS_QB'(1);

    typedef struct packed {
        logic             an, bn, cn;
        logic [QRS_W-1:0] am, bm, cm;
        logic             az, bz, cz;
    } t_s0;

    typedef struct packed {
        t_s0               s0;
        logic [QRS_PW-1:0] bb;
        logic [QRS_PW-1:0] ac;
    } t_s1;

    typedef struct packed {
        t_count cnt;
        t_dv    dv1;
        t_dv    dv2;
    } t_s4;

    logic              w_adv;
    logic              w_take;
    t_in_word          w_src;
    logic              r_skid_v;
    t_in_word          r_skid;
    logic [L-1:0]      r_vld;
    logic [QRS_TW-1:0] r_tol;

    t_s0      n_s0, r_s0;
    t_s1      n_s1, r_s1;
    t_ctx     n_ctx2, r_ctx2;
    t_sq      n_sq2, r_sq2;
    t_ctx     n_ctx3, r_ctx3;
    t_s4      n_s4, r_s4;
    t_out_word n_out, r_out;

    t_ctx   w_ctx [QRS_SW+1];
    t_sq    w_sq  [QRS_SW+1];
    t_dv    w_dv1 [QRS_QB+1];
    t_dv    w_dv2 [QRS_QB+1];
    t_count r_cnt [QRS_QB];

    // global advance: output empty or being taken
    assign w_adv       = !r_vld[L-1] || i_out_ready;
    assign o_in_ready  = !r_skid_v;
    assign o_cfg_ready = 1'b1;
    assign w_src       = r_skid_v ? r_skid : i_in_word;
    assign w_take      = r_skid_v || i_in_valid;

    // control: skid, valid chain, tolerance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
            r_vld    <= '0;
            r_tol    <= QRS_TW'(1);
        end else begin
            if (w_adv) begin
                r_vld    <= {r_vld[L-2:0], w_take};
                r_skid_v <= 1'b0;
            end else if (i_in_valid && !r_skid_v) begin
                r_skid_v <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && i_in_valid && !r_skid_v) begin
            r_skid <= i_in_word;
        end
    end

    // stage 0: sign / magnitude split and near-zero tests
    always_comb begin
        n_s0.an = w_src.coef_a[QRS_W-1];
        n_s0.bn = w_src.coef_b[QRS_W-1];
        n_s0.cn = w_src.coef_c[QRS_W-1];
        n_s0.am = n_s0.an ? QRS_W'(-w_src.coef_a) : QRS_W'(w_src.coef_a);
        n_s0.bm = n_s0.bn ? QRS_W'(-w_src.coef_b) : QRS_W'(w_src.coef_b);
        n_s0.cm = n_s0.cn ? QRS_W'(-w_src.coef_c) : QRS_W'(w_src.coef_c);
        n_s0.az = near_zero(n_s0.am, r_tol);
        n_s0.bz = near_zero(n_s0.bm, r_tol);
        n_s0.cz = near_zero(n_s0.cm, r_tol);
    end

    // stage 1: b*b and a*c magnitudes
    always_comb begin
        n_s1.s0 = r_s0;
        n_s1.bb = QRS_PW'(r_s0.bm) * QRS_PW'(r_s0.bm);
        n_s1.ac = QRS_PW'(r_s0.am) * QRS_PW'(r_s0.cm);
    end

    // stage 2: discriminant, case decision, divider operands
    logic [QRS_DDW-1:0] w_bb, w_ac4, w_sum, w_d;
    logic [QRS_DDW:0]   w_dif1, w_dif2;
    logic               w_dneg, w_dz;
    logic [QRS_DNW-1:0] w_a2;
    always_comb begin
        w_bb   = QRS_DDW'(r_s1.bb);
        w_ac4  = {1'b0, r_s1.ac, 2'b00};
        w_sum  = w_bb + w_ac4;
        w_dif1 = {1'b0, w_bb} - {1'b0, w_ac4};
        w_dif2 = {1'b0, w_ac4} - {1'b0, w_bb};
        if (r_s1.s0.an != r_s1.s0.cn) begin
            w_d    = w_sum;
            w_dneg = 1'b0;
        end else if (!w_dif1[QRS_DDW]) begin
            w_d    = QRS_DDW'(w_dif1);
            w_dneg = 1'b0;
        end else begin
            w_d    = QRS_DDW'(w_dif2);
            w_dneg = 1'b1;
        end
        w_dz = (w_d[QRS_DDW-1:QRS_F] == '0)
            || (w_d[QRS_DDW-1:QRS_F] < {{(QRS_DQW-QRS_TW){1'b0}}, r_tol});
        w_a2 = {r_s1.s0.am, 1'b0};

        n_ctx2       = '0;
        n_ctx2.cnt   = CNT_NONE;
        n_ctx2.an    = r_s1.s0.an;
        n_ctx2.bn    = r_s1.s0.bn;
        n_ctx2.bm    = r_s1.s0.bm;
        if (r_s1.s0.az) begin
            if (r_s1.s0.bz) begin
                n_ctx2.cnt = r_s1.s0.cz ? CNT_INF : CNT_NONE;
            end else begin
                n_ctx2.cnt   = CNT_ONE;
                n_ctx2.en1   = 1'b1;
                n_ctx2.qneg1 = !r_s1.s0.cn != r_s1.s0.bn;
                n_ctx2.n1mag = QRS_NW'(r_s1.s0.cm);
                n_ctx2.d1mag = QRS_DNW'(r_s1.s0.bm);
            end
        end else if (r_s1.s0.cz) begin
            n_ctx2.cnt   = CNT_TWO;
            n_ctx2.en2   = 1'b1;
            n_ctx2.qneg2 = !r_s1.s0.bn != r_s1.s0.an;
            n_ctx2.n2mag = QRS_NW'(r_s1.s0.bm);
            n_ctx2.d2mag = QRS_DNW'(r_s1.s0.am);
        end else if (w_dz) begin
            n_ctx2.cnt   = CNT_ONE;
            n_ctx2.en1   = 1'b1;
            n_ctx2.qneg1 = !r_s1.s0.bn != r_s1.s0.an;
            n_ctx2.n1mag = QRS_NW'(r_s1.s0.bm);
            n_ctx2.d1mag = w_a2;
        end else if (!w_dneg) begin
            n_ctx2.cnt   = CNT_TWO;
            n_ctx2.en1   = 1'b1;
            n_ctx2.en2   = 1'b1;
            n_ctx2.quad  = 1'b1;
            n_ctx2.d1mag = w_a2;
            n_ctx2.d2mag = w_a2;
        end

        n_sq2.rem  = '0;
        n_sq2.root = '0;
        n_sq2.dsh  = (2*QRS_SW)'(w_d);
    end

    // square root chain
    assign w_ctx[0] = r_ctx2;
    assign w_sq[0]  = r_sq2;
    for (genvar k = 0; k < QRS_SW; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_ctx (w_ctx[k]),
            .i_sq  (w_sq[k]),
            .o_ctx (w_ctx[k+1]),
            .o_sq  (w_sq[k+1])
        );
    end

    // stage 3: numerators -b - s and -b + s
    logic [QRS_NW-1:0] w_s, w_bmx, w_p, w_m1, w_m2, w_diff;
    logic              w_gt;
    always_comb begin
        n_ctx3 = w_ctx[QRS_SW];
        w_s    = QRS_NW'(w_sq[QRS_SW].root);
        w_bmx  = QRS_NW'(w_ctx[QRS_SW].bm);
        w_p    = w_bmx + w_s;
        w_m1   = w_bmx - w_s;
        w_m2   = w_s - w_bmx;
        w_gt   = w_s > w_bmx;
        w_diff = w_gt ? w_m2 : w_m1;
        if (w_ctx[QRS_SW].quad) begin
            if (w_ctx[QRS_SW].bn) begin
                n_ctx3.n1mag = w_diff;
                n_ctx3.qneg1 = w_gt != w_ctx[QRS_SW].an;
                n_ctx3.n2mag = w_p;
                n_ctx3.qneg2 = w_ctx[QRS_SW].an;
            end else begin
                n_ctx3.n1mag = w_p;
                n_ctx3.qneg1 = !w_ctx[QRS_SW].an;
                n_ctx3.n2mag = w_diff;
                n_ctx3.qneg2 = !w_gt != w_ctx[QRS_SW].an;
            end
        end
    end

    // stage 4: divider setup, overflow when quotient needs more than QB bits
    logic [QRS_DNW-1:0] w_hi1, w_hi2;
    always_comb begin
        w_hi1 = {{(QRS_DNW-QRS_HW){1'b0}}, r_ctx3.n1mag[QRS_NW-1 -: QRS_HW]};
        w_hi2 = {{(QRS_DNW-QRS_HW){1'b0}}, r_ctx3.n2mag[QRS_NW-1 -: QRS_HW]};
        n_s4.cnt      = r_ctx3.cnt;
        n_s4.dv1.en   = r_ctx3.en1;
        n_s4.dv1.qneg = r_ctx3.qneg1;
        n_s4.dv1.ovf  = w_hi1 >= r_ctx3.d1mag;
        n_s4.dv1.rem  = w_hi1;
        n_s4.dv1.dmag = r_ctx3.d1mag;
        n_s4.dv1.nlow = {r_ctx3.n1mag[QRS_QB-QRS_F-1:0], {QRS_F{1'b0}}};
        n_s4.dv1.q    = '0;
        n_s4.dv2.en   = r_ctx3.en2;
        n_s4.dv2.qneg = r_ctx3.qneg2;
        n_s4.dv2.ovf  = w_hi2 >= r_ctx3.d2mag;
        n_s4.dv2.rem  = w_hi2;
        n_s4.dv2.dmag = r_ctx3.d2mag;
        n_s4.dv2.nlow = {r_ctx3.n2mag[QRS_QB-QRS_F-1:0], {QRS_F{1'b0}}};
        n_s4.dv2.q    = '0;
    end

    // divider chains, count travels alongside
    assign w_dv1[0] = r_s4.dv1;
    assign w_dv2[0] = r_s4.dv2;
    for (genvar k = 0; k < QRS_QB; k++) begin : g_div
        qrs_div_cell u_div1 (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_dv  (w_dv1[k]),
            .o_dv  (w_dv1[k+1])
        );
        qrs_div_cell u_div2 (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_dv  (w_dv2[k]),
            .o_dv  (w_dv2[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cnt[k] <= (k == 0) ? r_s4.cnt : r_cnt[(k == 0) ? 0 : k-1];
            end
        end
    end

    // output: saturate, apply sign, zero unused roots
    logic w_sat1, w_sat2;
    t_dv  w_f1, w_f2;
    always_comb begin
        w_f1   = w_dv1[QRS_QB];
        w_f2   = w_dv2[QRS_QB];
        w_sat1 = w_f1.en && (w_f1.ovf || (w_f1.q > (w_f1.qneg ? LIM_NEG : LIM_POS)));
        w_sat2 = w_f2.en && (w_f2.ovf || (w_f2.q > (w_f2.qneg ? LIM_NEG : LIM_POS)));
        n_out.solution_count = r_cnt[QRS_QB-1];
        n_out.saturated      = w_sat1 || w_sat2;
        if (!w_f1.en) begin
            n_out.root_first = '0;
        end else if (w_sat1) begin
            n_out.root_first = QRS_W'(w_f1.qneg ? LIM_NEG : LIM_POS);
        end else begin
            n_out.root_first = w_f1.qneg ? QRS_W'(-w_f1.q) : QRS_W'(w_f1.q);
        end
        if (!w_f2.en) begin
            n_out.root_second = '0;
        end else if (w_sat2) begin
            n_out.root_second = QRS_W'(w_f2.qneg ? LIM_NEG : LIM_POS);
        end else begin
            n_out.root_second = w_f2.qneg ? QRS_W'(-w_f2.q) : QRS_W'(w_f2.q);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0   <= n_s0;
            r_s1   <= n_s1;
            r_ctx2 <= n_ctx2;
            r_sq2  <= n_sq2;
            r_ctx3 <= n_ctx3;
            r_s4   <= n_s4;
            r_out  <= n_out;
        end
    end

    assign o_out_valid = r_vld[L-1];
    assign o_out_word  = r_out;

endmodule

`default_nettype wire
